@@ src/wefc_pkg.sv @@
// Package for the weight element format converter.
// Holds format codes, status codes and the shared payload widths.
// No dependencies; every other file in src depends on it.
package wefc_pkg;

    localparam int ELEM_W     = 32;
    localparam int FMT_W      = 3;
    localparam int STATUS_W   = 3;
    localparam int CFG_IDX_W  = 2;

    typedef logic [ELEM_W-1:0]   elem_t;
    typedef logic [FMT_W-1:0]    fmt_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    // Source format codes
    localparam fmt_t SRC_BF16  = 3'd0;
    localparam fmt_t SRC_F32   = 3'd1;
    localparam fmt_t SRC_E4M3  = 3'd2;
    localparam fmt_t SRC_E8M0  = 3'd3;
    localparam fmt_t SRC_INT8  = 3'd4;
    localparam fmt_t SRC_UINT8 = 3'd5;

    // Target format codes
    localparam fmt_t TGT_BF16   = 3'd0;
    localparam fmt_t TGT_F32    = 3'd1;
    localparam fmt_t TGT_E4M3FN = 3'd2;
    localparam fmt_t TGT_E8M0   = 3'd3;
    localparam fmt_t TGT_E2M1   = 3'd4;

    // Configuration register indexes
    localparam cfg_idx_t REG_SOURCE_FORMAT = 2'd0;
    localparam cfg_idx_t REG_TARGET_FORMAT = 2'd1;

    localparam fmt_t SOURCE_FORMAT_RST = SRC_F32;
    localparam fmt_t TARGET_FORMAT_RST = TGT_BF16;

    // Status codes
    localparam status_t ST_OK            = 3'd0;
    localparam status_t ST_NONFINITE     = 3'd1;
    localparam status_t ST_BF16_OVERFLOW = 3'd2;
    localparam status_t ST_E8M0_INEXACT  = 3'd3;
    localparam status_t ST_E8M0_NAN      = 3'd4;
    localparam status_t ST_E4M3_NAN      = 3'd5;
    localparam status_t ST_UNSUPPORTED   = 3'd6;

    localparam elem_t F32_TWO_POW_M127   = 32'h0040_0000;
    localparam elem_t F32_SIGN_MANT_MASK = 32'h807f_ffff;
    localparam elem_t BF16_ROUND_BIAS    = 32'h0000_7fff;

    typedef struct packed {
        fmt_t source_format;
        fmt_t target_format;
    } fmt_cfg_t;

    typedef struct packed {
        elem_t   result_bits;
        status_t status;
    } result_t;

endpackage

@@ src/wefc_if.sv @@
// Channel interfaces for the weight element format converter.
// Depends on wefc_pkg for payload types.

interface wefc_elem_if;
    logic                 valid;
    logic                 ready;
    wefc_pkg::elem_t      element_bits;

    modport source (output valid, output element_bits, input ready);
    modport sink   (input valid, input element_bits, output ready);
endinterface

interface wefc_result_if;
    logic                 valid;
    logic                 ready;
    wefc_pkg::elem_t      result_bits;
    wefc_pkg::status_t    status;

    modport source (output valid, output result_bits, output status, input ready);
    modport sink   (input valid, input result_bits, input status, output ready);
endinterface

interface wefc_cfg_if;
    logic                 valid;
    logic                 ready;
    wefc_pkg::cfg_idx_t   index;
    wefc_pkg::fmt_t       data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/weight_element_format_convert.sv @@
// Weight element format converter: input register, conversion logic, result register.
// Top level; depends on wefc_pkg, the wefc interfaces, wefc_cfg_regs and wefc_convert.
//
// Converts one raw weight element per transfer under the configured source and target
// formats and returns the converted bits with a status code. The block accepts one
// element every clock cycle unless the result is stalled, and holds two elements in
// flight; an element is held in the input register, goes through a single pass
// of conversion logic and lands in the result register. A stalled result holds both
// stages, and the input side stays open while the input stage is empty or moving.
// Configuration is sampled as an element passes through the conversion logic, so write
// it only while the block is empty. Nothing needs clearing after reset.
module weight_element_format_convert (
    input  logic           clk,
    input  logic           rst_n,
    wefc_cfg_if.sink       cfg,
    wefc_elem_if.sink      elem,
    wefc_result_if.source  result
);
    import wefc_pkg::*;

    fmt_cfg_t fmt_cfg;
    result_t  conv;

    logic     elem_valid_reg;
    elem_t    elem_reg;
    logic     res_valid_reg;
    result_t  res_reg;
    logic     res_load;
    logic     elem_load;

    wefc_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .fmt_cfg (fmt_cfg)
    );

    wefc_convert u_convert (
        .fmt_cfg (fmt_cfg),
        .raw     (elem_reg),
        .result  (conv)
    );

    // advance the input stage when the result stage is empty or its transfer completes
    assign res_load   = elem_valid_reg && (!res_valid_reg || result.ready);
    assign elem.ready = !elem_valid_reg || res_load;
    assign elem_load  = elem.valid && elem.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            if (elem.ready)
                elem_valid_reg <= elem.valid;
            if (!res_valid_reg || result.ready)
                res_valid_reg <= elem_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (elem_load)
            elem_reg <= elem.element_bits;
        if (res_load)
            res_reg <= conv;
    end

    assign result.valid       = res_valid_reg;
    assign result.result_bits = res_reg.result_bits;
    assign result.status      = res_reg.status;

endmodule

@@ src/wefc_cfg_regs.sv @@
// Format configuration registers of the weight element format converter.
// Depends on wefc_pkg and the wefc_cfg_if interface.
module wefc_cfg_regs (
    input  logic                clk,
    input  logic                rst_n,
    wefc_cfg_if.sink            cfg,
    output wefc_pkg::fmt_cfg_t  fmt_cfg
);
    import wefc_pkg::*;

    fmt_t source_format_reg;
    fmt_t target_format_reg;
    logic write_en;

    assign cfg.ready = 1'b1;
    assign write_en  = cfg.valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            source_format_reg <= SOURCE_FORMAT_RST;
            target_format_reg <= TARGET_FORMAT_RST;
        end
        else if (write_en)
        begin
            // drop writes to indexes past the register list
            case (cfg.index)
                REG_SOURCE_FORMAT: source_format_reg <= cfg.data;
                REG_TARGET_FORMAT: target_format_reg <= cfg.data;
                default: ;
            endcase
        end
    end

    assign fmt_cfg.source_format = source_format_reg;
    assign fmt_cfg.target_format = target_format_reg;

endmodule

@@ src/wefc_convert.sv @@
// Combinational conversion and checking of one weight element.
// Depends on wefc_pkg.
module wefc_convert (
    input  wefc_pkg::fmt_cfg_t fmt_cfg,
    input  wefc_pkg::elem_t    raw,
    output wefc_pkg::result_t  result
);
    import wefc_pkg::*;

    fmt_t        src;
    fmt_t        tgt;
    logic        fp_src;
    logic        allowed;
    elem_t       bits;
    logic        nonfinite;
    elem_t       rnd_sum;
    logic [15:0] bf16_val;
    logic [7:0]  f32_exp;
    status_t     st;
    elem_t       value;

    assign src    = fmt_cfg.source_format;
    assign tgt    = fmt_cfg.target_format;
    assign fp_src = (src == SRC_BF16) || (src == SRC_F32);

    always_comb
    begin
        case (tgt)
            TGT_BF16, TGT_F32: allowed = fp_src;
            TGT_E4M3FN:        allowed = (src == SRC_E4M3);
            TGT_E8M0:          allowed = (src == SRC_E8M0) || (src == SRC_F32);
            TGT_E2M1:          allowed = (src == SRC_INT8) || (src == SRC_UINT8);
            default:           allowed = 1'b0;
        endcase
    end

    // widen BF16 to an F32 pattern, keep only the source's bytes otherwise
    always_comb
    begin
        if (src == SRC_F32)
            bits = raw;
        else if (src == SRC_BF16)
            bits = {raw[15:0], 16'h0000};
        else
            bits = {24'h000000, raw[7:0]};
    end

    assign nonfinite = fp_src && (bits[30:23] == 8'hff);
    assign rnd_sum   = bits + BF16_ROUND_BIAS + {31'd0, bits[16]};
    assign bf16_val  = rnd_sum[31:16];
    assign f32_exp   = bits[30:23];

    always_comb
    begin
        st    = ST_OK;
        value = '0;
        if (!allowed)
            st = ST_UNSUPPORTED;
        else if (nonfinite)
            st = ST_NONFINITE;
        else
        begin
            case (tgt)
                TGT_BF16:
                begin
                    if (bf16_val[14:7] == 8'hff)
                        st = ST_BF16_OVERFLOW;
                    else
                        value = {16'h0000, bf16_val};
                end
                TGT_F32:
                    value = bits;
                TGT_E8M0:
                begin
                    if (src == SRC_F32)
                    begin
                        // exact powers of two only; 2^-127 maps to code zero
                        if (bits == F32_TWO_POW_M127)
                            value = '0;
                        else if (((bits & F32_SIGN_MANT_MASK) == '0) && (f32_exp != 8'h00))
                            value = {24'h000000, f32_exp};
                        else
                            st = ST_E8M0_INEXACT;
                    end
                    else if (bits[7:0] == 8'hff)
                        st = ST_E8M0_NAN;
                    else
                        value = {24'h000000, bits[7:0]};
                end
                TGT_E4M3FN:
                begin
                    if (bits[6:0] == 7'h7f)
                        st = ST_E4M3_NAN;
                    else
                        value = {24'h000000, bits[7:0]};
                end
                TGT_E2M1:
                    value = {24'h000000, bits[7:0]};
                default:
                    st = ST_UNSUPPORTED;
            endcase
        end
    end

    assign result.result_bits = value;
    assign result.status      = st;

endmodule

@@ src/wefc_checker.sv @@
// Port-level checks for the weight element format converter, bound to the top level.
// Depends on wefc_pkg.
module wefc_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic              out_valid,
    input  logic              out_ready,
    input  wefc_pkg::elem_t   out_bits,
    input  wefc_pkg::status_t out_status
);
    import wefc_pkg::*;

    logic in_xfer;

    assign in_xfer = in_valid && in_ready;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_bits) && $stable(out_status))
        else $error("result changed while stalled");

    // error results carry zero bits
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_status != ST_OK) |-> out_bits == '0)
        else $error("error result with nonzero bits");

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_status <= ST_UNSUPPORTED)
        else $error("status code out of range");

    // a fresh result is preceded by an element transfer
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_xfer, 2))
        else $error("result without a matching element transfer");

endmodule

bind weight_element_format_convert wefc_checker u_wefc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (elem.valid),
    .in_ready   (elem.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_bits   (result.result_bits),
    .out_status (result.status)
);
